// File: rtl/ptf_pkg.sv
// Shared types and constants of the Petri net transition fire unit.
// Used by ptf_ctrl, ptf_dp and petri_transition_fire_unit; no dependencies.
package ptf_pkg;

    // Store geometry
    localparam int PLACE_COUNT = 64;
    localparam int PLACE_BITS  = $clog2(PLACE_COUNT);
    localparam int TOKEN_BITS  = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int INDEX_BITS  = 6;
    localparam int READ_BITS   = 16;

    // Output-arc row: {bounded, capacity, weight}
    localparam int OUT_ROW_BITS = 1 + 2 * WEIGHT_BITS;

    // Item action codes
    typedef enum logic [2:0] {
        ACT_WRITE    = 3'd0,
        ACT_ARC_IN   = 3'd1,
        ACT_ARC_OUT  = 3'd2,
        ACT_ARC_INH  = 3'd3,
        ACT_DEL_INH  = 3'd4,
        ACT_TEST     = 3'd5,
        ACT_FIRE     = 3'd6,
        ACT_READ     = 3'd7
    } t_action;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the accepted item
        logic wr_exec;   // perform a store write action
        logic rd_place;  // read the marking at the addressed place
        logic cnt_clr;   // restart the place counter
        logic scan_rd;   // read place under counter for the enable check
        logic fire_rd;   // read place under counter for update and write back
        logic finish;    // load the result registers
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_action action;
        logic    cnt_last;
        logic    ok;
    } t_dp_sts;

endpackage

// File: rtl/ptf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ptf_ctrl.sv
// Control state machine of the transition fire unit: sequences item actions.
// Depends on ptf_pkg; drives ptf_dp through t_dp_cmd.
module ptf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  ptf_pkg::t_dp_sts i_sts,
    output ptf_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_EXEC     = 10'b00_0000_0010,
        S_RD_ISSUE = 10'b00_0000_0100,
        S_RD_DONE  = 10'b00_0000_1000,
        S_SCAN     = 10'b00_0001_0000,
        S_SCAN_END = 10'b00_0010_0000,
        S_DECIDE   = 10'b00_0100_0000,
        S_FIRE     = 10'b00_1000_0000,
        S_FIRE_END = 10'b01_0000_0000,
        S_FIN      = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // latched action picks the path
                unique case (i_sts.action) inside
                    ptf_pkg::ACT_TEST,
                    ptf_pkg::ACT_FIRE: n_state = S_SCAN;
                    ptf_pkg::ACT_READ: n_state = S_RD_ISSUE;
                    default: begin
                        o_cmd.wr_exec = 1'b1;
                        o_cmd.finish  = 1'b1;
                        n_state       = S_IDLE;
                    end
                endcase
            end
            S_RD_ISSUE: begin
                o_cmd.rd_place = 1'b1;
                n_state        = S_RD_DONE;
            end
            S_RD_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if ((i_sts.action == ptf_pkg::ACT_FIRE) && i_sts.ok) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_FIRE;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FIRE: begin
                o_cmd.fire_rd = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_FIRE_END;
                end
            end
            S_FIRE_END: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/ptf_dp.sv
// Datapath of the transition fire unit: marking and arc stores, place check,
// fire update and result registers. Depends on ptf_pkg and ptf_ram.
module ptf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptf_pkg::t_dp_cmd               i_cmd,
    input  logic [2:0]                     i_action,
    input  logic [ptf_pkg::INDEX_BITS-1:0] i_place_index,
    input  logic [ptf_pkg::WEIGHT_BITS-1:0] i_amount,
    input  logic [ptf_pkg::WEIGHT_BITS-1:0] i_capacity_value,
    input  logic                           i_capacity_bounded,
    output ptf_pkg::t_dp_sts               o_sts,
    output logic                           o_result_valid,
    output logic                           o_enabled,
    output logic                           o_fired,
    output logic [ptf_pkg::READ_BITS-1:0]  o_token_count,
    output logic                           o_saturated
);

    localparam int PB    = ptf_pkg::PLACE_BITS;
    localparam int TB    = ptf_pkg::TOKEN_BITS;
    localparam int WB    = ptf_pkg::WEIGHT_BITS;
    localparam int OB    = ptf_pkg::OUT_ROW_BITS;
    localparam int SUM_W = ((TB > WB) ? TB : WB) + 2;
    localparam logic [TB-1:0] COUNT_MAX = '1;

    // Latched item
    ptf_pkg::t_action    r_action;
    logic [PB-1:0]       r_place;
    logic                r_in_range;
    logic [WB-1:0]       r_amount;
    logic [WB-1:0]       r_cap;
    logic                r_bounded;

    // Per-place arc flags, and marking valid bits set once a place is written
    logic [ptf_pkg::PLACE_COUNT-1:0] r_flag_in;
    logic [ptf_pkg::PLACE_COUNT-1:0] r_flag_out;
    logic [ptf_pkg::PLACE_COUNT-1:0] r_flag_inh;
    logic [ptf_pkg::PLACE_COUNT-1:0] r_mark_vld;

    // Scan counter and read pipeline
    logic [PB-1:0] r_cnt;
    logic          r_chk;
    logic          r_wb;
    logic [PB-1:0] r_idx_q;
    logic          r_in_q;
    logic          r_out_q;
    logic          r_inh_q;
    logic          r_mvld_q;
    logic          r_ok;
    logic          r_sat;

    // Result registers
    logic                r_res_vld;
    logic                r_res_en;
    logic                r_res_fired;
    logic [ptf_pkg::READ_BITS-1:0] r_res_count;
    logic                r_res_sat;

    logic [PB-1:0] raddr;
    logic [TB-1:0] mark_rdata;
    logic [WB-1:0] inw_rdata;
    logic [OB-1:0] out_rdata;
    logic [WB-1:0] inh_rdata;
    logic [TB-1:0] mark_q;
    logic [WB-1:0] outw_q;
    logic [WB-1:0] cap_q;
    logic          bounded_q;
    logic [SUM_W-1:0] cap_sum;
    logic [SUM_W-1:0] fire_sum;
    logic          over;
    logic [TB-1:0] fire_val;
    logic          place_ok;
    logic          wr_mark;
    logic          wr_inw;
    logic          wr_out;
    logic          wr_inh;
    logic          del_inh;
    logic          mark_we;
    logic [PB-1:0] mark_waddr;
    logic [TB-1:0] mark_wdata;

    // Store write decode for the single-place actions
    always_comb begin
        wr_mark = 1'b0;
        wr_inw  = 1'b0;
        wr_out  = 1'b0;
        wr_inh  = 1'b0;
        del_inh = 1'b0;
        if (i_cmd.wr_exec && r_in_range) begin
            unique case (r_action)
                ptf_pkg::ACT_WRITE:   wr_mark = 1'b1;
                ptf_pkg::ACT_ARC_IN:  wr_inw  = 1'b1;
                ptf_pkg::ACT_ARC_OUT: wr_out  = 1'b1;
                ptf_pkg::ACT_ARC_INH: wr_inh  = 1'b1;
                ptf_pkg::ACT_DEL_INH: del_inh = 1'b1;
                default: ;
            endcase
        end
    end

    // Marking port is shared by token writes and fire write back
    assign mark_we    = wr_mark || r_wb;
    assign mark_waddr = r_wb ? r_idx_q : r_place;
    assign mark_wdata = r_wb ? fire_val : TB'(r_amount);

    assign raddr = i_cmd.rd_place ? r_place : r_cnt;

    ptf_ram #(.WIDTH(TB), .DEPTH(ptf_pkg::PLACE_COUNT)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (raddr),
        .o_rdata (mark_rdata)
    );

    ptf_ram #(.WIDTH(WB), .DEPTH(ptf_pkg::PLACE_COUNT)) u_inw_ram (
        .i_clk   (i_clk),
        .i_we    (wr_inw),
        .i_waddr (r_place),
        .i_wdata (r_amount),
        .i_raddr (raddr),
        .o_rdata (inw_rdata)
    );

    ptf_ram #(.WIDTH(OB), .DEPTH(ptf_pkg::PLACE_COUNT)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (wr_out),
        .i_waddr (r_place),
        .i_wdata ({r_bounded, r_cap, r_amount}),
        .i_raddr (raddr),
        .o_rdata (out_rdata)
    );

    ptf_ram #(.WIDTH(WB), .DEPTH(ptf_pkg::PLACE_COUNT)) u_inh_ram (
        .i_clk   (i_clk),
        .i_we    (wr_inh),
        .i_waddr (r_place),
        .i_wdata (r_amount),
        .i_raddr (raddr),
        .o_rdata (inh_rdata)
    );

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action   <= ptf_pkg::t_action'(i_action);
            r_place    <= i_place_index[PB-1:0];
            r_in_range <= (int'(i_place_index) < ptf_pkg::PLACE_COUNT);
            r_amount   <= i_amount;
            r_cap      <= i_capacity_value;
            r_bounded  <= i_capacity_bounded;
        end
    end

    // Flags and marking valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_in  <= '0;
            r_flag_out <= '0;
            r_flag_inh <= '0;
            r_mark_vld <= '0;
        end else begin
            if (wr_inw) begin
                r_flag_in[r_place] <= 1'b1;
            end
            if (wr_out) begin
                r_flag_out[r_place] <= 1'b1;
            end
            if (wr_inh) begin
                r_flag_inh[r_place] <= 1'b1;
            end
            if (del_inh) begin
                r_flag_inh[r_place] <= 1'b0;
            end
            if (mark_we) begin
                r_mark_vld[mark_waddr] <= 1'b1;
            end
        end
    end

    // Place counter and read pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_chk <= 1'b0;
            r_wb  <= 1'b0;
            r_ok  <= 1'b0;
            r_sat <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_rd;
            r_wb  <= i_cmd.fire_rd;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.scan_rd || i_cmd.fire_rd) begin
                r_cnt <= r_cnt + PB'(1);
            end
            if (i_cmd.latch) begin
                r_ok  <= 1'b1;
                r_sat <= 1'b0;
            end else begin
                if (r_chk && !place_ok) begin
                    r_ok <= 1'b0;
                end
                if (r_wb && over) begin
                    r_sat <= 1'b1;
                end
            end
        end
    end

    // Side information aligned with the registered read data
    always_ff @(posedge i_clk) begin
        r_idx_q  <= raddr;
        r_in_q   <= r_flag_in[raddr];
        r_out_q  <= r_flag_out[raddr];
        r_inh_q  <= r_flag_inh[raddr];
        r_mvld_q <= r_mark_vld[raddr];
    end

    assign mark_q    = r_mvld_q ? mark_rdata : '0;
    assign outw_q    = out_rdata[WB-1:0];
    assign cap_q     = out_rdata[2*WB-1:WB];
    assign bounded_q = out_rdata[OB-1];

    // Enable check of one place
    assign cap_sum  = SUM_W'(mark_q) + SUM_W'(outw_q);
    assign place_ok = !(r_in_q && (SUM_W'(mark_q) < SUM_W'(inw_rdata)))
                   && !(r_inh_q && (SUM_W'(mark_q) >= SUM_W'(inh_rdata)))
                   && !(r_out_q && bounded_q && (cap_sum > SUM_W'(cap_q)));

    // Fire update: remove input weight, add output weight, clip at max
    assign fire_sum = SUM_W'(mark_q)
                    - (r_in_q  ? SUM_W'(inw_rdata) : SUM_W'(0))
                    + (r_out_q ? SUM_W'(outw_q)    : SUM_W'(0));
    assign over     = fire_sum > SUM_W'(COUNT_MAX);
    assign fire_val = over ? COUNT_MAX : fire_sum[TB-1:0];

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_en    <= ((r_action == ptf_pkg::ACT_TEST) ||
                            (r_action == ptf_pkg::ACT_FIRE)) && r_ok;
            r_res_fired <= (r_action == ptf_pkg::ACT_FIRE) && r_ok;
            r_res_sat   <= (r_action == ptf_pkg::ACT_FIRE) && r_ok && r_sat;
            r_res_count <= ((r_action == ptf_pkg::ACT_READ) && r_in_range)
                         ? ptf_pkg::READ_BITS'(mark_q) : '0;
        end
    end

    assign o_sts.action   = r_action;
    assign o_sts.cnt_last = (r_cnt == PB'(ptf_pkg::PLACE_COUNT - 1));
    assign o_sts.ok       = r_ok;

    assign o_result_valid = r_res_vld;
    assign o_enabled      = r_res_en;
    assign o_fired        = r_res_fired;
    assign o_token_count  = r_res_count;
    assign o_saturated    = r_res_sat;

endmodule

// File: rtl/petri_transition_fire_unit.sv
// Top level of the Petri net transition fire unit: controller plus datapath.
// Depends on ptf_pkg, ptf_ctrl, ptf_dp (and ptf_ram through ptf_dp).
//
// One transition with input, output and inhibitor arcs over 64 places and
// their 16-bit token counts. An item is taken when start is high and busy is
// low; busy then stays high until the item is done, and exactly one result
// appears on o_result_valid for a single cycle. The receiver cannot stall it,
// so it must capture every strobed result. Test and fire walk the places
// through the marking and weight memories one place per cycle (read port
// bound); an enabled fire makes a second pass that writes each updated count
// back. The marking reads as zero after reset and all arc flags are cleared;
// no clearing pass is needed.
module petri_transition_fire_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_action,
    input  logic [ptf_pkg::INDEX_BITS-1:0]  i_place_index,
    input  logic [ptf_pkg::WEIGHT_BITS-1:0] i_amount,
    input  logic [ptf_pkg::WEIGHT_BITS-1:0] i_capacity_value,
    input  logic                            i_capacity_bounded,
    output logic                            o_result_valid,
    output logic                            o_enabled,
    output logic                            o_fired,
    output logic [ptf_pkg::READ_BITS-1:0]   o_token_count,
    output logic                            o_saturated
);

    ptf_pkg::t_dp_cmd cmd;
    ptf_pkg::t_dp_sts sts;

    ptf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ptf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_action           (i_action),
        .i_place_index      (i_place_index),
        .i_amount           (i_amount),
        .i_capacity_value   (i_capacity_value),
        .i_capacity_bounded (i_capacity_bounded),
        .o_sts              (sts),
        .o_result_valid     (o_result_valid),
        .o_enabled          (o_enabled),
        .o_fired            (o_fired),
        .o_token_count      (o_token_count),
        .o_saturated        (o_saturated)
    );

    // A result only ever follows a cycle in which an item was in work
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without an item in work");

    // An accepted item keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the unit busy");

    // Store read sources are mutually exclusive
    a_one_read_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.scan_rd, cmd.fire_rd, cmd.rd_place}))
        else $error("two read sources in one cycle");

    // A fired result is always an enabled one, and saturation only on fire
    a_fired_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_fired || o_saturated) |-> o_enabled && o_fired)
        else $error("fire flags inconsistent");

endmodule

// File: bench/tb.sv
// Self-checking bench for petri_transition_fire_unit: a directed pass, then random nets.
// Keeps its own copy of the marking and arcs and predicts each result.
// Depends on ptf_pkg and the RTL of petri_transition_fire_unit.
`timescale 1ns / 1ps

module tb;

    typedef logic [ptf_pkg::INDEX_BITS-1:0]  t_index;
    typedef logic [ptf_pkg::WEIGHT_BITS-1:0] t_weight;
    typedef logic [ptf_pkg::TOKEN_BITS-1:0]  t_tokens;

    // One result of the block
    typedef struct packed {
        logic                            enabled;
        logic                            fired;
        logic [ptf_pkg::READ_BITS-1:0]   token_count;
        logic                            saturated;
    } t_item_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [2:0]                      i_action;
    logic [ptf_pkg::INDEX_BITS-1:0]  i_place_index;
    logic [ptf_pkg::WEIGHT_BITS-1:0] i_amount;
    logic [ptf_pkg::WEIGHT_BITS-1:0] i_capacity_value;
    logic                            i_capacity_bounded;
    logic                            o_result_valid;
    logic                            o_enabled;
    logic                            o_fired;
    logic [ptf_pkg::READ_BITS-1:0]   o_token_count;
    logic                            o_saturated;

    // Predicted net: marking plus arcs of the single transition
    t_tokens net_tokens  [ptf_pkg::PLACE_COUNT];
    t_weight in_weight   [ptf_pkg::PLACE_COUNT];
    t_weight out_weight  [ptf_pkg::PLACE_COUNT];
    t_weight inh_weight  [ptf_pkg::PLACE_COUNT];
    t_weight cap_limit   [ptf_pkg::PLACE_COUNT];
    logic    has_in      [ptf_pkg::PLACE_COUNT];
    logic    has_out     [ptf_pkg::PLACE_COUNT];
    logic    has_inh     [ptf_pkg::PLACE_COUNT];
    logic    cap_bounded [ptf_pkg::PLACE_COUNT];
    // Places whose arcs must be undone before the next random net
    logic    arc_touched [ptf_pkg::PLACE_COUNT];

    t_item_result pending_item_results[$];
    int           fail_count;
    int           items_sent;
    bit           idle_on;

    petri_transition_fire_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_place_index      (i_place_index),
        .i_amount           (i_amount),
        .i_capacity_value   (i_capacity_value),
        .i_capacity_bounded (i_capacity_bounded),
        .o_result_valid     (o_result_valid),
        .o_enabled          (o_enabled),
        .o_fired            (o_fired),
        .o_token_count      (o_token_count),
        .o_saturated        (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Every place must pass its input, inhibitor and capacity conditions
    function automatic bit net_transition_enabled();
        int unsigned sum;
        for (int p = 0; p < ptf_pkg::PLACE_COUNT; p++) begin
            if (has_in[p] && net_tokens[p] < in_weight[p])
                return 1'b0;
            if (has_inh[p] && net_tokens[p] >= inh_weight[p])
                return 1'b0;
            sum = 32'(net_tokens[p]) + 32'(out_weight[p]);
            if (has_out[p] && cap_bounded[p] && sum > 32'(cap_limit[p]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Update the predicted net for one item and return the result it causes
    function automatic t_item_result apply_item_to_net(input ptf_pkg::t_action act,
                                                       input t_index p,
                                                       input t_weight amt,
                                                       input t_weight cap,
                                                       input logic bnd);
        t_item_result r;
        int unsigned  t;
        r = '0;
        case (act)
            ptf_pkg::ACT_WRITE: net_tokens[p] = amt;
            ptf_pkg::ACT_ARC_IN: begin
                in_weight[p] = amt;
                has_in[p]    = 1'b1;
            end
            ptf_pkg::ACT_ARC_OUT: begin
                out_weight[p]  = amt;
                has_out[p]     = 1'b1;
                cap_limit[p]   = cap;
                cap_bounded[p] = bnd;
            end
            ptf_pkg::ACT_ARC_INH: begin
                inh_weight[p] = amt;
                has_inh[p]    = 1'b1;
            end
            ptf_pkg::ACT_DEL_INH: begin
                inh_weight[p] = '0;
                has_inh[p]    = 1'b0;
            end
            ptf_pkg::ACT_TEST: r.enabled = net_transition_enabled();
            ptf_pkg::ACT_FIRE: begin
                if (net_transition_enabled()) begin
                    r.enabled = 1'b1;
                    r.fired   = 1'b1;
                    // take input weight first, then add output weight, clip at max
                    for (int q = 0; q < ptf_pkg::PLACE_COUNT; q++) begin
                        t = 32'(net_tokens[q]);
                        if (has_in[q])
                            t = t - 32'(in_weight[q]);
                        if (has_out[q])
                            t = t + 32'(out_weight[q]);
                        if (t > 32'h0000_FFFF) begin
                            t           = 32'h0000_FFFF;
                            r.saturated = 1'b1;
                        end
                        net_tokens[q] = t[ptf_pkg::TOKEN_BITS-1:0];
                    end
                end
            end
            default: r.token_count = net_tokens[p];
        endcase
        return r;
    endfunction

    // Transfer one item: random hold-off, raise start, wait until taken
    task automatic send_item(input ptf_pkg::t_action act, input int unsigned idx,
                             input int unsigned amt, input int unsigned cap,
                             input int unsigned bnd);
        int unsigned gap;
        t_index      p;
        t_weight     a;
        t_weight     cv;
        logic        b;
        p   = t_index'(idx);
        a   = t_weight'(amt);
        cv  = t_weight'(cap);
        b   = bnd[0];
        gap = idle_on ? $urandom_range(0, 18) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start              = 1'b1;
        i_action           = act;
        i_place_index      = p;
        i_amount           = a;
        i_capacity_value   = cv;
        i_capacity_bounded = b;
        do @(posedge i_clk); while (busy);
        pending_item_results = {pending_item_results, apply_item_to_net(act, p, a, cv, b)};
        if (act inside {ptf_pkg::ACT_ARC_IN, ptf_pkg::ACT_ARC_OUT, ptf_pkg::ACT_ARC_INH})
            arc_touched[p] = 1'b1;
        items_sent++;
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_item_result exp_r;
        if (i_rst_n && o_result_valid) begin
            if (pending_item_results.size() == 0) begin
                $error("result strobed with no item outstanding");
                fail_count++;
            end else begin
                exp_r = pending_item_results.pop_front();
                if (o_enabled !== exp_r.enabled) begin
                    $error("enabled: expected %0d, got %0d", exp_r.enabled, o_enabled);
                    fail_count++;
                end
                if (o_fired !== exp_r.fired) begin
                    $error("fired: expected %0d, got %0d", exp_r.fired, o_fired);
                    fail_count++;
                end
                if (o_token_count !== exp_r.token_count) begin
                    $error("token_count: expected %0d, got %0d",
                           exp_r.token_count, o_token_count);
                    fail_count++;
                end
                if (o_saturated !== exp_r.saturated) begin
                    $error("saturated: expected %0d, got %0d", exp_r.saturated, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // Stores read zero and an empty net is enabled
    task automatic test_reset_state();
        send_item(ptf_pkg::ACT_READ, 0, 0, 0, 0);
        send_item(ptf_pkg::ACT_READ, 63, 'hFFFF, 'hFFFF, 1);
        send_item(ptf_pkg::ACT_TEST, 0, 0, 0, 0);
    endtask

    // Largest and smallest counts written and read back
    task automatic test_write_extremes();
        send_item(ptf_pkg::ACT_WRITE, 63, 'hFFFF, 0, 0);
        send_item(ptf_pkg::ACT_READ, 63, 0, 0, 0);
        send_item(ptf_pkg::ACT_WRITE, 63, 0, 'hFFFF, 1);
        send_item(ptf_pkg::ACT_READ, 63, 0, 0, 0);
    endtask

    // A zero-weight inhibitor always blocks; removal, also of a missing arc
    task automatic test_inhibitor_arcs();
        send_item(ptf_pkg::ACT_ARC_INH, 5, 0, 0, 0);
        send_item(ptf_pkg::ACT_TEST, 0, 0, 0, 0);
        send_item(ptf_pkg::ACT_DEL_INH, 5, 0, 0, 0);
        send_item(ptf_pkg::ACT_TEST, 0, 0, 0, 0);
        send_item(ptf_pkg::ACT_DEL_INH, 6, 0, 0, 0);
    endtask

    // Disabled fire leaves the marking; enabled fire moves tokens and clips
    task automatic test_fire_and_saturation();
        send_item(ptf_pkg::ACT_ARC_IN, 1, 3, 0, 0);
        send_item(ptf_pkg::ACT_FIRE, 0, 0, 0, 0);
        send_item(ptf_pkg::ACT_WRITE, 1, 5, 0, 0);
        send_item(ptf_pkg::ACT_ARC_OUT, 2, 'hFFFF, 0, 0);
        send_item(ptf_pkg::ACT_WRITE, 2, 'h0010, 0, 0);
        send_item(ptf_pkg::ACT_FIRE, 0, 0, 0, 0);
        send_item(ptf_pkg::ACT_READ, 1, 0, 0, 0);
        send_item(ptf_pkg::ACT_READ, 2, 0, 0, 0);
    endtask

    // Bounded capacity blocks; overwriting arcs, zero input weight
    task automatic test_capacity_bound();
        send_item(ptf_pkg::ACT_ARC_IN, 1, 0, 0, 0);
        send_item(ptf_pkg::ACT_ARC_OUT, 2, 1, 'hFFFF, 1);
        send_item(ptf_pkg::ACT_TEST, 0, 0, 0, 0);
        send_item(ptf_pkg::ACT_ARC_OUT, 2, 0, 'hFFFF, 1);
        send_item(ptf_pkg::ACT_FIRE, 0, 0, 0, 0);
    endtask

    // Small random nets, then fired, tested, read, inhibitor removals and random items
    task automatic test_random_nets();
        int unsigned net_places [4];
        int unsigned k, n, sel, m, w, c;
        while (items_sent < 1700) begin
            idle_on = ($urandom_range(0, 3) != 0);
            // undo arcs left by the previous net
            for (int q = 0; q < ptf_pkg::PLACE_COUNT; q++) begin
                if (arc_touched[q]) begin
                    send_item(ptf_pkg::ACT_ARC_IN, q, 0, $urandom_range(0, 65535), 1);
                    send_item(ptf_pkg::ACT_ARC_OUT, q, 0, $urandom_range(0, 65535), 0);
                    send_item(ptf_pkg::ACT_DEL_INH, q, $urandom_range(0, 65535), 0, 0);
                    arc_touched[q] = 1'b0;
                end
            end
            // build the net
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
                net_places[i] = $urandom_range(0, ptf_pkg::PLACE_COUNT - 1);
                m = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 40);
                send_item(ptf_pkg::ACT_WRITE, net_places[i], m, $urandom_range(0, 65535),
                          $urandom_range(0, 1));
                if ($urandom_range(0, 2) != 0) begin
                    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 6);
                    send_item(ptf_pkg::ACT_ARC_IN, net_places[i], w,
                              $urandom_range(0, 65535), $urandom_range(0, 1));
                end
                if ($urandom_range(0, 2) == 0) begin
                    w = ($urandom_range(0, 4) == 0) ? $urandom_range(65000, 65535)
                                                    : $urandom_range(0, 6);
                    c = m + w * $urandom_range(0, 4) + $urandom_range(0, 2);
                    if (c > 65535 || $urandom_range(0, 5) == 0)
                        c = $urandom_range(0, 65535);
                    send_item(ptf_pkg::ACT_ARC_OUT, net_places[i], w, c,
                              $urandom_range(0, 1));
                end
                if ($urandom_range(0, 3) == 0) begin
                    w = m + $urandom_range(0, 12);
                    if (w > 65535 || $urandom_range(0, 7) == 0)
                        w = $urandom_range(0, 65535);
                    send_item(ptf_pkg::ACT_ARC_INH, net_places[i], w,
                              $urandom_range(0, 65535), $urandom_range(0, 1));
                end
            end
            // exercise it
            n = $urandom_range(3, 10);
            for (int j = 0; j < n; j++) begin
                sel = $urandom_range(0, 9);
                if (sel <= 3)
                    send_item(ptf_pkg::ACT_FIRE, $urandom_range(0, 63),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
                else if (sel <= 5)
                    send_item(ptf_pkg::ACT_TEST, $urandom_range(0, 63),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
                else if (sel <= 7)
                    send_item(ptf_pkg::ACT_READ,
                              ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63)
                                  : net_places[$urandom_range(0, k - 1)],
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
                else if (sel == 8)
                    send_item(ptf_pkg::ACT_DEL_INH, net_places[$urandom_range(0, k - 1)],
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
                else
                    send_item(ptf_pkg::t_action'($urandom_range(0, 7)),
                              $urandom_range(0, 63),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
            end
        end
    endtask

    // Predicted stores start as after reset
    initial begin
        for (int p = 0; p < ptf_pkg::PLACE_COUNT; p++) begin
            net_tokens[p]  = '0;
            in_weight[p]   = '0;
            out_weight[p]  = '0;
            inh_weight[p]  = '0;
            cap_limit[p]   = '0;
            has_in[p]      = 1'b0;
            has_out[p]     = 1'b0;
            has_inh[p]     = 1'b0;
            cap_bounded[p] = 1'b0;
            arc_touched[p] = 1'b0;
        end
    end

    // Main sequence
    initial begin
        fail_count         = 0;
        items_sent         = 0;
        idle_on            = 1'b1;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_action           = ptf_pkg::ACT_WRITE;
        i_place_index      = '0;
        i_amount           = '0;
        i_capacity_value   = '0;
        i_capacity_bounded = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_write_extremes();
        test_inhibitor_arcs();
        test_fire_and_saturation();
        test_capacity_bound();
        test_random_nets();

        @(negedge i_clk);
        start = 1'b0;
        wait (pending_item_results.size() == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #25_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
